// ===== sv/qrm_pkg.sv =====
// ---------------------------------------------------------------------------
// qrm_pkg
// Shared constants for the quaternion to rotation matrix core.
// ---------------------------------------------------------------------------
`default_nettype none

package qrm_pkg;

    // Matrix elements are signed Q1.15.
    localparam int OUT_W     = 16;
    // Quotient bits: floor(|v| * 2^16), which reaches 2^16 for |v| = 1.
    localparam int Q_BITS    = 17;
    // One step for the integer bit, then one per fraction bit.
    localparam int DIV_STEPS = Q_BITS;
    localparam int N_ELEM    = 9;
    localparam int N_PROD    = 10;

    localparam logic signed [OUT_W-1:0] Q15_MAX = 16'sh7FFF;

    // Product slots of the multiply stage.
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_ZW = 5;
    localparam int P_XZ = 6;
    localparam int P_YW = 7;
    localparam int P_YZ = 8;
    localparam int P_XW = 9;

endpackage

`default_nettype wire

// ===== sv/qrm_if.sv =====
// ---------------------------------------------------------------------------
// qrm_in_if / qrm_out_if
// Valid/ready channels for quaternion words and matrix words.
// ---------------------------------------------------------------------------
`default_nettype none

interface qrm_in_if #(
    parameter int COMPONENT_WIDTH = 16
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] qx;
    logic signed [COMPONENT_WIDTH-1:0] qy;
    logic signed [COMPONENT_WIDTH-1:0] qz;
    logic signed [COMPONENT_WIDTH-1:0] qw;

    modport source (output valid, qx, qy, qz, qw, input ready);
    modport sink   (input valid, qx, qy, qz, qw, output ready);
endinterface

interface qrm_out_if;
    import qrm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
    logic                    degenerate;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    degenerate, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    degenerate, output ready);
endinterface

`default_nettype wire

// ===== sv/quaternion_to_rotation_matrix_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Converts a signed Q2.14 quaternion into a normalized Q1.15 rotation matrix.
// ---------------------------------------------------------------------------
// Usage: quaternion words enter on i_quat (qx, qy, qz, qw), matrix words
// leave on o_mat (r00..r22 and degenerate). Both are valid/ready channels;
// a word moves on a clock edge with valid and ready high.
// The quaternion need not be unit length: every element is divided by the
// squared norm with a pipelined restoring divider, one quotient bit per
// stage, nine lanes wide. Rounding is to nearest, ties away from zero,
// and +1.0 saturates to 32767.
// Pipeline: 21 register stages (input register, multiply, sums, 17 divider
// steps, output register).
// Throughput: one word per cycle while the receiver takes words; a word can
// enter on every clock edge unless the output stalls.
// A zero quaternion gives a zero matrix with degenerate set.
// When the receiver stalls, the whole pipeline holds and i_quat.ready
// drops in the same cycle; no word is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; the pipeline
// is empty afterwards.
// ---------------------------------------------------------------------------
`default_nettype none

module quaternion_to_rotation_matrix_core #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qrm_in_if.sink     i_quat,
    qrm_out_if.source  o_mat
);
    import qrm_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int PW = 2 * CW;   // product width
    localparam int NW = PW + 2;   // norm and numerator width
    localparam int SW = NW + 1;   // signed sum width

    logic en;

    // Stage 0: input register.
    logic                 r_v0;
    logic signed [CW-1:0] r_x, r_y, r_z, r_w;

    // Stage 1: products.
    logic                 r_v1;
    logic signed [PW-1:0] r_p [N_PROD];

    // Stage 2: norm, numerators and signs.
    logic                 r_v2;
    logic                 r_dg2;
    logic [NW-1:0]        r_n2;
    logic [NW-1:0]        r_num [N_ELEM];
    logic                 r_sg2 [N_ELEM];
    logic signed [SW-1:0] pe    [N_PROD];
    logic signed [SW-1:0] n_sum [N_ELEM];
    logic signed [SW-1:0] n_norm;

    // Divider steps.
    logic                r_vd  [DIV_STEPS];
    logic                r_dgd [DIV_STEPS];
    logic [NW-1:0]       r_dn  [DIV_STEPS];
    logic [NW-1:0]       r_rem [DIV_STEPS][N_ELEM];
    logic [Q_BITS-1:0]   r_q   [DIV_STEPS][N_ELEM];
    logic                r_sgd [DIV_STEPS][N_ELEM];
    logic [NW-1:0]       n_rem [DIV_STEPS][N_ELEM];
    logic [Q_BITS-1:0]   n_q   [DIV_STEPS][N_ELEM];

    // Output register.
    logic                    r_ov;
    logic                    r_odg;
    logic signed [OUT_W-1:0] r_o  [N_ELEM];
    logic signed [OUT_W-1:0] n_o  [N_ELEM];

    // The pipeline moves whenever the output slot is free or being taken.
    assign en           = !r_ov || o_mat.ready;
    assign i_quat.ready = en;

    always_comb begin
        for (int i = 0; i < N_PROD; i++) begin
            pe[i] = SW'(r_p[i]);
        end
        n_norm   = pe[P_XX] + pe[P_YY] + pe[P_ZZ] + pe[P_WW];
        n_sum[0] = (pe[P_XX] + pe[P_WW]) - (pe[P_YY] + pe[P_ZZ]);
        n_sum[4] = (pe[P_YY] + pe[P_WW]) - (pe[P_XX] + pe[P_ZZ]);
        n_sum[8] = (pe[P_ZZ] + pe[P_WW]) - (pe[P_XX] + pe[P_YY]);
        // Off-diagonal numerators carry the factor of two.
        n_sum[1] = (pe[P_XY] + pe[P_ZW]) <<< 1;
        n_sum[2] = (pe[P_XZ] - pe[P_YW]) <<< 1;
        n_sum[3] = (pe[P_XY] - pe[P_ZW]) <<< 1;
        n_sum[5] = (pe[P_YZ] + pe[P_XW]) <<< 1;
        n_sum[6] = (pe[P_XZ] + pe[P_YW]) <<< 1;
        n_sum[7] = (pe[P_YZ] - pe[P_XW]) <<< 1;
    end

    always_comb begin : div_step
        logic [NW:0]       t;
        logic [NW:0]       nn;
        logic [NW:0]       diff;
        logic [Q_BITS-1:0] qprev;
        logic              ge;
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int k = 0; k < N_ELEM; k++) begin
                if (j == 0) begin
                    t     = {1'b0, r_num[k]};
                    nn    = {1'b0, r_n2};
                    qprev = '0;
                end else begin
                    t     = {r_rem[j-1][k], 1'b0};
                    nn    = {1'b0, r_dn[j-1]};
                    qprev = r_q[j-1][k];
                end
                ge          = (t >= nn);
                diff        = t - nn;
                n_rem[j][k] = ge ? diff[NW-1:0] : t[NW-1:0];
                n_q[j][k]   = {qprev[Q_BITS-2:0], ge};
            end
        end
    end

    always_comb begin : round_sat
        logic [Q_BITS:0] m;
        for (int k = 0; k < N_ELEM; k++) begin
            m = ({1'b0, r_q[DIV_STEPS-1][k]} + 1'b1) >> 1;
            if (r_dgd[DIV_STEPS-1]) begin
                n_o[k] = '0;
            end else if (r_sgd[DIV_STEPS-1][k]) begin
                n_o[k] = OUT_W'(-$signed({1'b0, m}));
            end else if (m > (Q_BITS+1)'(Q15_MAX)) begin
                n_o[k] = Q15_MAX;
            end else begin
                n_o[k] = OUT_W'(m);
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_vd[j] <= 1'b0;
            end
        end else if (en) begin
            r_v0    <= i_quat.valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_vd[0] <= r_v2;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_vd[j] <= r_vd[j-1];
            end
            r_ov <= r_vd[DIV_STEPS-1];
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= i_quat.qx;
            r_y <= i_quat.qy;
            r_z <= i_quat.qz;
            r_w <= i_quat.qw;

            r_p[P_XX] <= r_x * r_x;
            r_p[P_YY] <= r_y * r_y;
            r_p[P_ZZ] <= r_z * r_z;
            r_p[P_WW] <= r_w * r_w;
            r_p[P_XY] <= r_x * r_y;
            r_p[P_ZW] <= r_z * r_w;
            r_p[P_XZ] <= r_x * r_z;
            r_p[P_YW] <= r_y * r_w;
            r_p[P_YZ] <= r_y * r_z;
            r_p[P_XW] <= r_x * r_w;

            r_n2  <= n_norm[NW-1:0];
            r_dg2 <= (n_norm == '0);
            for (int k = 0; k < N_ELEM; k++) begin
                r_sg2[k] <= n_sum[k][SW-1];
                r_num[k] <= n_sum[k][SW-1] ? NW'(-n_sum[k]) : n_sum[k][NW-1:0];
            end

            r_dn[0]  <= r_n2;
            r_dgd[0] <= r_dg2;
            for (int k = 0; k < N_ELEM; k++) begin
                r_sgd[0][k] <= r_sg2[k];
            end
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dn[j]  <= r_dn[j-1];
                r_dgd[j] <= r_dgd[j-1];
                for (int k = 0; k < N_ELEM; k++) begin
                    r_sgd[j][k] <= r_sgd[j-1][k];
                end
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                for (int k = 0; k < N_ELEM; k++) begin
                    r_rem[j][k] <= n_rem[j][k];
                    r_q[j][k]   <= n_q[j][k];
                end
            end

            r_odg <= r_dgd[DIV_STEPS-1];
            for (int k = 0; k < N_ELEM; k++) begin
                r_o[k] <= n_o[k];
            end
        end
    end

    assign o_mat.valid      = r_ov;
    assign o_mat.degenerate = r_odg;
    assign o_mat.r00        = r_o[0];
    assign o_mat.r01        = r_o[1];
    assign o_mat.r02        = r_o[2];
    assign o_mat.r10        = r_o[3];
    assign o_mat.r11        = r_o[4];
    assign o_mat.r12        = r_o[5];
    assign o_mat.r20        = r_o[6];
    assign o_mat.r21        = r_o[7];
    assign o_mat.r22        = r_o[8];

    // A stalled output word must hold the whole pipeline.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_mat.ready) |-> !i_quat.ready)
        else $error("input accepted while output stalled");

    // A degenerate word carries an all-zero matrix.
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mat.valid && o_mat.degenerate) |->
            (o_mat.r00 == '0 && o_mat.r01 == '0 && o_mat.r02 == '0 &&
             o_mat.r10 == '0 && o_mat.r11 == '0 && o_mat.r12 == '0 &&
             o_mat.r20 == '0 && o_mat.r21 == '0 && o_mat.r22 == '0))
        else $error("degenerate word with nonzero element");

    // A zero norm means every numerator is zero too.
    a_zero_norm_numerators: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_dg2) |-> (r_num[0] == '0 && r_num[1] == '0 && r_num[4] == '0))
        else $error("zero norm with nonzero numerator");

    // Every numerator is bounded by the norm, so no quotient exceeds one.
    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd[DIV_STEPS-1] && !r_dgd[DIV_STEPS-1]) |->
            (r_q[DIV_STEPS-1][0] <= (Q_BITS)'(1 << (Q_BITS-1)) &&
             r_q[DIV_STEPS-1][1] <= (Q_BITS)'(1 << (Q_BITS-1))))
        else $error("quotient above one");

endmodule

`default_nettype wire
